/* src/rmc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared widths, codes and fixed-point constants of the ray march core.
// ----------------------------------------------------------------------------
package rmc_pkg;

    // field widths
    localparam int COORD_W     = 11;
    localparam int RADIUS_W    = 10;
    localparam int PIXEL_W     = 12;
    localparam int RAY_INDEX_W = 9;
    localparam int DIR_W       = 17;
    localparam int CFG_IDX_W   = 3;

    // stream words
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // direction table covers every ray_index code
    localparam int TABLE_DEPTH = 1 << RAY_INDEX_W;

    // output buffer
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // radius squared in whole pixels
    localparam int RAD_SQ_W = 2 * RADIUS_W;

    // angle math in Q30
    localparam longint          Q30_ONE    = 64'sd1 <<< 30;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_X   = 3'd0,
        CFG_SOURCE_Y   = 3'd1,
        CFG_OBSTACLE_X = 3'd2,
        CFG_OBSTACLE_Y = 3'd3,
        CFG_RADIUS     = 3'd4,
        CFG_SCREEN_W   = 3'd5,
        CFG_SCREEN_H   = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

endpackage
`default_nettype wire

/* src/rmc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* src/ray_march_to_circle_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ray_march_to_circle_core
// Fixed-step 2D ray march from a source point toward a blocking circle.
//
// Input words (s_*): tuser selects start (0) or advance (1); a start loads
// the direction for ray_index and puts the position at the source, an
// advance moves one unit step and gives one output word with the pixel.
// Output words (m_*): pixel x/y, tlast ends the ray (off screen or inside
// the circle), tuser flags the obstacle hit. Starts and advances with no
// ray running give no word. Config writes (cfg_*) are taken every cycle.
// Throughput: one input word per clock while s_tready is high. Each word
// passes the state read-modify-write (ray state RAM read, update, write
// back with forwarding), then the distance, square and compare stages.
// A stalled receiver fills an eight-word output FIFO; s_tready drops when
// FIFO words plus words in flight reach eight, so nothing is lost.
// Reset: no ray running, FIFO empty, registers at their default values.
// ----------------------------------------------------------------------------
module ray_march_to_circle_core
    import rmc_pkg::*;
#(
    parameter int unsigned RAY_COUNT     = 512,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [8:0] ray_index, rest zero
    input  wire logic                 s_tuser,  // [0] func
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // [11:0] pixel_x, [23:12] pixel_y
    output logic                      m_tlast,
    output logic                      m_tuser,  // [0] hit_obstacle
    // register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data
);

    localparam int POS_W    = PIXEL_W + FRACTION_BITS;
    localparam int DIFF_W   = POS_W + 1;
    localparam int UP       = (FRACTION_BITS >= 15) ? FRACTION_BITS - 15 : 0;
    localparam int DOWN     = (FRACTION_BITS < 15) ? 15 - FRACTION_BITS : 0;
    localparam int NEAR_W   = RADIUS_W + FRACTION_BITS;
    localparam int SQ_W     = 2 * NEAR_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int STATE_W  = 2 * POS_W + 2 * DIR_W;
    localparam int FIFO_W   = 2 * PIXEL_W + 2;
    localparam int STATE_DEPTH = 1;

    // ------------------------------------------------------------------
    // direction table, built at elaboration
    // ------------------------------------------------------------------
    function automatic longint qmul(input longint a, input longint b);
        longint unsigned p;
        p = $unsigned(a) * $unsigned(b);
        return $signed(p >> 30);
    endfunction

    function automatic longint to_q15(input longint v);
        longint t;
        t = v;
        if (t < 0) t = 0;
        if (t > Q30_ONE) t = Q30_ONE;
        return (t + 16384) >>> 15;
    endfunction

    // returns {sin, cos} of a first-octant angle in 2^-32 turns
    function automatic logic [2*DIR_W-1:0] trig_pair(input longint unsigned r);
        longint x, x2, x3, x4, x5, x6, x7, x8, x9, x10;
        longint s, c;
        x   = $signed((r * TWO_PI_Q30) >> 32);
        x2  = qmul(x, x);
        x3  = qmul(x2, x);
        x4  = qmul(x2, x2);
        x5  = qmul(x4, x);
        x6  = qmul(x4, x2);
        x7  = qmul(x6, x);
        x8  = qmul(x4, x4);
        x9  = qmul(x8, x);
        x10 = qmul(x8, x2);
        s = to_q15(x - x3 / 6 + x5 / 120 - x7 / 5040 + x9 / 362880);
        c = to_q15(Q30_ONE - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320
                   - x10 / 3628800);
        return {s[DIR_W-1:0], c[DIR_W-1:0]};
    endfunction

    // returns {dir_y, dir_x} for a ray index already below RAY_COUNT
    function automatic logic [2*DIR_W-1:0] dir_entry(input int unsigned idx);
        longint unsigned a, q, r;
        logic [2*DIR_W-1:0] sc;
        logic signed [DIR_W-1:0] s0, c0, dx, dy;
        a = (64'(idx) << 32) / RAY_COUNT;
        q = (a >> 30) & 64'd3;
        r = a & ((64'd1 << 30) - 64'd1);
        if (r > (64'd1 << 29)) begin
            sc = trig_pair((64'd1 << 30) - r);
            c0 = sc[2*DIR_W-1:DIR_W];
            s0 = sc[DIR_W-1:0];
        end else begin
            sc = trig_pair(r);
            s0 = sc[2*DIR_W-1:DIR_W];
            c0 = sc[DIR_W-1:0];
        end
        case (q[1:0])
            2'd0: begin
                dx = c0;
                dy = s0;
            end
            2'd1: begin
                dx = -s0;
                dy = c0;
            end
            2'd2: begin
                dx = -c0;
                dy = -s0;
            end
            default: begin
                dx = s0;
                dy = -c0;
            end
        endcase
        return {dy, dx};
    endfunction

    logic [2*DIR_W-1:0] dir_table [TABLE_DEPTH];

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_dir
        localparam logic [2*DIR_W-1:0] ENTRY = dir_entry(i % RAY_COUNT);
        assign dir_table[i] = ENTRY;
    end

    // ------------------------------------------------------------------
    // step helpers
    // ------------------------------------------------------------------
    function automatic logic signed [POS_W-1:0] scale_dir(
        input logic signed [DIR_W-1:0] d
    );
        logic signed [POS_W-1:0] e;
        e = {{(POS_W-DIR_W){d[DIR_W-1]}}, d};
        return (e <<< UP) >>> DOWN;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic [DIFF_W-1:0] v);
        if (v[DIFF_W-1] != v[DIFF_W-2]) begin
            return {v[DIFF_W-1], {(POS_W-1){~v[DIFF_W-1]}}};
        end
        return v[POS_W-1:0];
    endfunction

    // truncation toward zero
    function automatic logic [PIXEL_W-1:0] trunc_pixel(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] t;
        t = p + (p[POS_W-1] ? {{(POS_W-FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}}
                            : {POS_W{1'b0}});
        return t[POS_W-1:FRACTION_BITS];
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [COORD_W-1:0]  src_x_reg, src_y_reg, obs_x_reg, obs_y_reg;
    logic [COORD_W-1:0]  scr_w_reg, scr_h_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [RAD_SQ_W-1:0] rad_sq_reg;
    logic                cfg_accept;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_x_reg  <= COORD_W'(200);
            src_y_reg  <= COORD_W'(200);
            obs_x_reg  <= COORD_W'(650);
            obs_y_reg  <= COORD_W'(300);
            radius_reg <= RADIUS_W'(140);
            scr_w_reg  <= COORD_W'(900);
            scr_h_reg  <= COORD_W'(600);
        end else if (cfg_accept) begin
            case (cfg_reg_t'(cfg_index))
                CFG_SOURCE_X:   src_x_reg  <= cfg_data;
                CFG_SOURCE_Y:   src_y_reg  <= cfg_data;
                CFG_OBSTACLE_X: obs_x_reg  <= cfg_data;
                CFG_OBSTACLE_Y: obs_y_reg  <= cfg_data;
                CFG_RADIUS:     radius_reg <= cfg_data[RADIUS_W-1:0];
                CFG_SCREEN_W:   scr_w_reg  <= cfg_data;
                CFG_SCREEN_H:   scr_h_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rad_sq_reg <= RAD_SQ_W'(radius_reg) * RAD_SQ_W'(radius_reg);
    end

    // ------------------------------------------------------------------
    // stage 0: accept, table read
    // ------------------------------------------------------------------
    logic                s_accept;
    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic                start1_reg, start2_reg, start3_reg, start4_reg;
    logic [2*DIR_W-1:0]  dir_rom_reg;
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    reserved;

    assign s_accept = s_tvalid & s_tready;
    assign reserved = occ_reg + CNT_W'(v1_reg) + CNT_W'(v2_reg)
                    + CNT_W'(v3_reg) + CNT_W'(v4_reg);
    assign s_tready = reserved < CNT_W'(FIFO_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= s_accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        start1_reg <= (func_t'(s_tuser) == FUNC_START);
        if (s_accept) begin
            dir_rom_reg <= dir_table[s_tdata[RAY_INDEX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: ray state read-modify-write
    // ------------------------------------------------------------------
    logic [STATE_W-1:0]      ram_rdata, cur_state, new_state, fwd_reg;
    logic                    wr_last_reg;
    logic [POS_W-1:0]        cur_px, cur_py, new_px, new_py;
    logic signed [DIR_W-1:0] cur_dx, cur_dy, new_dx, new_dy;
    logic [DIFF_W-1:0]       sum_x, sum_y;
    logic [POS_W-1:0]        step_x, step_y;

    rmc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .clk     (aclk),
        .wr_en   (v1_reg),
        .wr_addr (1'b0),
        .wr_data (new_state),
        .rd_addr (1'b0),
        .rd_data (ram_rdata)
    );

    // back-to-back words see the state written by the word just before them
    assign cur_state = wr_last_reg ? fwd_reg : ram_rdata;
    assign cur_px = cur_state[POS_W-1:0];
    assign cur_py = cur_state[2*POS_W-1:POS_W];
    assign cur_dx = cur_state[2*POS_W+DIR_W-1:2*POS_W];
    assign cur_dy = cur_state[STATE_W-1:2*POS_W+DIR_W];

    assign step_x = scale_dir(cur_dx);
    assign step_y = scale_dir(cur_dy);
    assign sum_x  = {cur_px[POS_W-1], cur_px} + {step_x[POS_W-1], step_x};
    assign sum_y  = {cur_py[POS_W-1], cur_py} + {step_y[POS_W-1], step_y};

    always_comb begin
        if (start1_reg) begin
            new_px = {1'b0, src_x_reg, {FRACTION_BITS{1'b0}}};
            new_py = {1'b0, src_y_reg, {FRACTION_BITS{1'b0}}};
            new_dx = dir_rom_reg[DIR_W-1:0];
            new_dy = dir_rom_reg[2*DIR_W-1:DIR_W];
        end else begin
            new_px = sat_pos(sum_x);
            new_py = sat_pos(sum_y);
            new_dx = cur_dx;
            new_dy = cur_dy;
        end
    end

    assign new_state = {new_dy, new_dx, new_py, new_px};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_last_reg <= 1'b0;
        end else begin
            wr_last_reg <= v1_reg;
        end
    end

    logic [POS_W-1:0] px2_reg, py2_reg;

    always_ff @(posedge aclk) begin
        fwd_reg    <= new_state;
        start2_reg <= start1_reg;
        px2_reg    <= new_px;
        py2_reg    <= new_py;
    end

    // ------------------------------------------------------------------
    // stage 2: bounds, distance to center, pixel
    // ------------------------------------------------------------------
    logic [DIFF_W-1:0]  diff_x, diff_y, abs_x, abs_y;
    logic [NEAR_W-1:0]  rr;
    logic               near, off;
    logic               off3_reg, near3_reg;
    logic [NEAR_W-1:0]  ax3_reg, ay3_reg;
    logic [PIXEL_W-1:0] pix_x3_reg, pix_y3_reg;

    assign diff_x = {px2_reg[POS_W-1], px2_reg}
                  - {2'b00, obs_x_reg, {FRACTION_BITS{1'b0}}};
    assign diff_y = {py2_reg[POS_W-1], py2_reg}
                  - {2'b00, obs_y_reg, {FRACTION_BITS{1'b0}}};
    assign abs_x  = diff_x[DIFF_W-1] ? -diff_x : diff_x;
    assign abs_y  = diff_y[DIFF_W-1] ? -diff_y : diff_y;
    assign rr     = {radius_reg, {FRACTION_BITS{1'b0}}};
    assign near   = (abs_x < {{(DIFF_W-NEAR_W){1'b0}}, rr})
                 && (abs_y < {{(DIFF_W-NEAR_W){1'b0}}, rr});
    assign off    = px2_reg[POS_W-1] || py2_reg[POS_W-1]
                 || (px2_reg[POS_W-2:0] > {scr_w_reg, {FRACTION_BITS{1'b0}}})
                 || (py2_reg[POS_W-2:0] > {scr_h_reg, {FRACTION_BITS{1'b0}}});

    always_ff @(posedge aclk) begin
        start3_reg <= start2_reg;
        off3_reg   <= off;
        near3_reg  <= near;
        ax3_reg    <= abs_x[NEAR_W-1:0];
        ay3_reg    <= abs_y[NEAR_W-1:0];
        pix_x3_reg <= trunc_pixel(px2_reg);
        pix_y3_reg <= trunc_pixel(py2_reg);
    end

    // ------------------------------------------------------------------
    // stage 3: squares
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]    xsq4_reg, ysq4_reg;
    logic               off4_reg, near4_reg;
    logic [PIXEL_W-1:0] pix_x4_reg, pix_y4_reg;

    always_ff @(posedge aclk) begin
        start4_reg <= start3_reg;
        off4_reg   <= off3_reg;
        near4_reg  <= near3_reg;
        pix_x4_reg <= pix_x3_reg;
        pix_y4_reg <= pix_y3_reg;
        xsq4_reg   <= SQ_W'(ax3_reg) * SQ_W'(ax3_reg);
        ysq4_reg   <= SQ_W'(ay3_reg) * SQ_W'(ay3_reg);
    end

    // ------------------------------------------------------------------
    // stage 4: circle test, ray end, result push
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] dist_sq;
    logic [SQ_W-1:0]  rad_sq_q;
    logic             hit, last, push, pop;
    logic             ray_active_reg;

    assign dist_sq  = {1'b0, xsq4_reg} + {1'b0, ysq4_reg};
    assign rad_sq_q = {rad_sq_reg, {(2*FRACTION_BITS){1'b0}}};
    assign hit      = near4_reg && (dist_sq < {1'b0, rad_sq_q});
    assign last     = off4_reg || hit;
    // words behind an ended ray are dropped here, in order
    assign push     = v4_reg && !start4_reg && ray_active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ray_active_reg <= 1'b0;
        end else if (v4_reg) begin
            if (start4_reg) begin
                ray_active_reg <= 1'b1;
            end else if (ray_active_reg && last) begin
                ray_active_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output FIFO
    // ------------------------------------------------------------------
    logic [FIFO_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_W-1:0] head;

    assign m_tvalid = (occ_reg != '0);
    assign pop      = m_tvalid & m_tready;
    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tdata  = head[2*PIXEL_W-1:0];
    assign m_tlast  = head[2*PIXEL_W];
    assign m_tuser  = head[2*PIXEL_W+1];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= {hit, last, pix_y4_reg, pix_x4_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            occ_reg <= occ_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(FIFO_DEPTH))
        else $error("output fifo occupancy above depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (occ_reg < CNT_W'(FIFO_DEPTH)))
        else $error("result pushed into a full fifo");

    a_start_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && start4_reg) |=> ray_active_reg)
        else $error("start word did not arm the ray");

    a_push_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> $past(s_tvalid && s_tready, 4))
        else $error("result without an input word four cycles earlier");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ray march core. A queue-fed driver offers start
// and advance words, a clocked predictor computes the pixel each advance must
// give, and a monitor compares every output word against the oldest pending
// pixel. Directed rays cover the table axes, restart, saturation, zero radius
// and the hit-on-edge case; randomized phases re-program the registers and
// run mostly well-formed rays with random gaps and a long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
    import rmc_pkg::*;

    localparam int RAYS       = 512;
    localparam int FRAC       = 16;
    localparam int SETTLE     = 10;
    localparam int STALL_LEN  = 300;
    localparam int QUIET_MAX  = 2000;

    typedef struct {
        func_t            func;
        logic [RAY_INDEX_W-1:0] idx;
    } march_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] px;
        logic [PIXEL_W-1:0] py;
        logic               last;
        logic               hit;
    } pixel_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COORD_W-1:0]     cfg_data  = '0;

    ray_march_to_circle_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // register shadow
    logic [COORD_W-1:0]  src_x = 11'd200, src_y = 11'd200;
    logic [COORD_W-1:0]  obs_x = 11'd650, obs_y = 11'd300;
    logic [RADIUS_W-1:0] obs_r = 10'd140;
    logic [COORD_W-1:0]  scr_w = 11'd900, scr_h = 11'd600;

    // ray state
    longint pos_x = 0, pos_y = 0, dir_x = 0, dir_y = 0;
    bit     ray_on = 1'b0;

    march_item_t item_queue[$];
    pixel_t      pixel_queue[$];
    int          bad_words = 0;
    bit          idle_on = 1'b1;
    int          stall_ticket = 0;

    // ------------------------------------------------------------------------
    // direction table math
    // ------------------------------------------------------------------------
    function automatic longint to_q15(input longint v);
        if (v < 0) v = 0;
        if (v > Q30_ONE) v = Q30_ONE;
        return (v + 16384) >>> 15;
    endfunction

    function automatic void octant_sin_cos(input longint unsigned r,
                                           output longint s, output longint c);
        longint unsigned x, x2, x3, x4, x5, x6, x7, x8, x9, x10;
        x   = (r * TWO_PI_Q30) >> 32;
        x2  = (x * x) >> 30;
        x3  = (x2 * x) >> 30;
        x4  = (x2 * x2) >> 30;
        x5  = (x4 * x) >> 30;
        x6  = (x4 * x2) >> 30;
        x7  = (x6 * x) >> 30;
        x8  = (x4 * x4) >> 30;
        x9  = (x8 * x) >> 30;
        x10 = (x8 * x2) >> 30;
        s = to_q15(longint'(x) - longint'(x3) / 6 + longint'(x5) / 120
                   - longint'(x7) / 5040 + longint'(x9) / 362880);
        c = to_q15(Q30_ONE - longint'(x2) / 2 + longint'(x4) / 24
                   - longint'(x6) / 720 + longint'(x8) / 40320
                   - longint'(x10) / 3628800);
    endfunction

    task automatic load_heading(input logic [RAY_INDEX_W-1:0] idx);
        longint unsigned a, q, r;
        longint s0, c0;
        a = (64'(idx % RAYS) << 32) / RAYS;
        q = (a >> 30) & 3;
        r = a & ((64'd1 << 30) - 1);
        // upper half of a quadrant is folded onto the lower half
        if (r > (64'd1 << 29)) octant_sin_cos((64'd1 << 30) - r, c0, s0);
        else octant_sin_cos(r, s0, c0);
        case (q)
            0: begin dir_x = c0;  dir_y = s0;  end
            1: begin dir_x = -s0; dir_y = c0;  end
            2: begin dir_x = -c0; dir_y = -s0; end
            default: begin dir_x = s0; dir_y = -c0; end
        endcase
    endtask

    function automatic longint clamp_pos(input longint v);
        longint lim;
        lim = 64'sd1 <<< (11 + FRAC);
        if (v < -lim) return -lim;
        if (v > lim - 1) return lim - 1;
        return v;
    endfunction

    function automatic logic [PIXEL_W-1:0] to_pixel(input longint p);
        longint t;
        t = (p >= 0) ? (p >>> FRAC) : -((-p) >>> FRAC);
        return t[PIXEL_W-1:0];
    endfunction

    function automatic bit in_circle();
        longint dx, dy;
        longint unsigned ax, ay, rr;
        dx = pos_x - (longint'(obs_x) <<< FRAC);
        dy = pos_y - (longint'(obs_y) <<< FRAC);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        rr = longint'(obs_r) <<< FRAC;
        if (ax >= rr || ay >= rr) return 1'b0;
        return (ax * ax + ay * ay) < (rr * rr);
    endfunction

    // one accepted input word: update the ray and queue the pixel it gives
    task automatic march_step(input func_t f, input logic [RAY_INDEX_W-1:0] idx);
        pixel_t w;
        bit     off, hit;
        if (f == FUNC_START) begin
            load_heading(idx);
            pos_x  = longint'(src_x) <<< FRAC;
            pos_y  = longint'(src_y) <<< FRAC;
            ray_on = 1'b1;
        end else if (ray_on) begin
            pos_x = clamp_pos(pos_x + (dir_x <<< (FRAC - 15)));
            pos_y = clamp_pos(pos_y + (dir_y <<< (FRAC - 15)));
            off = pos_x < 0 || pos_x > (longint'(scr_w) <<< FRAC)
               || pos_y < 0 || pos_y > (longint'(scr_h) <<< FRAC);
            hit = in_circle();
            if (off || hit) ray_on = 1'b0;
            w.px   = to_pixel(pos_x);
            w.py   = to_pixel(pos_y);
            w.last = off || hit;
            w.hit  = hit;
            pixel_queue.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------------
    march_item_t cur_item;
    int          send_wait = 0;
    bit          offering;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait = 0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                march_step(cur_item.func, cur_item.idx);
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (item_queue.size() > 0) begin
                    cur_item = item_queue.pop_front();
                    s_tdata  <= {{(S_TDATA_W-RAY_INDEX_W){1'b0}}, cur_item.idx};
                    s_tuser  <= cur_item.func;
                    offering = 1'b1;
                    send_wait = idle_on ? $urandom_range(0, 13) : 0;
                end
            end
            s_tvalid <= offering;
        end
    end

    // ------------------------------------------------------------------------
    // output monitor
    // ------------------------------------------------------------------------
    int     recv_wait = 0;
    int     hold_left = 0;
    int     seen_ticket = 0;
    bit     have_want, ready_next;
    pixel_t got, want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.px   = m_tdata[PIXEL_W-1:0];
                got.py   = m_tdata[2*PIXEL_W-1:PIXEL_W];
                got.last = m_tlast;
                got.hit  = m_tuser;
                have_want = pixel_queue.size() > 0;
                want = have_want ? pixel_queue.pop_front() : '0;
                if (!have_want || got.px !== want.px || got.py !== want.py
                        || got.last !== want.last || got.hit !== want.hit) begin
                    bad_words++;
                    if (bad_words <= 10) begin
                        $display({"mismatch%s: expected x=%0d y=%0d last=%0d hit=%0d,",
                                  " got x=%0d y=%0d last=%0d hit=%0d"},
                                 have_want ? "" : " (no word expected)",
                                 $signed(want.px), $signed(want.py), want.last, want.hit,
                                 $signed(got.px), $signed(got.py), got.last, got.hit);
                    end
                end
                recv_wait = idle_on ? $urandom_range(0, 13) : 0;
            end
            if (stall_ticket != seen_ticket) begin
                seen_ticket = stall_ticket;
                hold_left = STALL_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic write_reg(input cfg_reg_t r, input logic [COORD_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (r)
            CFG_SOURCE_X:   src_x = v;
            CFG_SOURCE_Y:   src_y = v;
            CFG_OBSTACLE_X: obs_x = v;
            CFG_OBSTACLE_Y: obs_y = v;
            CFG_RADIUS:     obs_r = v[RADIUS_W-1:0];
            CFG_SCREEN_W:   scr_w = v;
            CFG_SCREEN_H:   scr_h = v;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic setup(input int sx, input int sy, input int ox, input int oy,
                         input int r, input int w, input int h);
        write_reg(CFG_SOURCE_X, COORD_W'(sx));
        write_reg(CFG_SOURCE_Y, COORD_W'(sy));
        write_reg(CFG_OBSTACLE_X, COORD_W'(ox));
        write_reg(CFG_OBSTACLE_Y, COORD_W'(oy));
        write_reg(CFG_RADIUS, COORD_W'(r));
        write_reg(CFG_SCREEN_W, COORD_W'(w));
        write_reg(CFG_SCREEN_H, COORD_W'(h));
    endtask

    task automatic random_setup(input bit wide);
        int w, h;
        if (wide) begin
            setup($urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 1023), $urandom_range(1, 2047),
                  $urandom_range(1, 2047));
        end else begin
            // small screens so most rays run to their end
            w = $urandom_range(1, 64);
            h = $urandom_range(1, 64);
            setup($urandom_range(0, w), $urandom_range(0, h),
                  $urandom_range(0, w + 16), $urandom_range(0, h + 16),
                  $urandom_range(0, 24), w, h);
        end
    endtask

    task automatic push_item(input func_t f, input int idx);
        march_item_t it;
        it.func = f;
        it.idx  = RAY_INDEX_W'(idx);
        item_queue.push_back(it);
    endtask

    task automatic push_ray(input int idx, input int steps);
        push_item(FUNC_START, idx);
        repeat (steps) push_item(FUNC_ADVANCE, 0);
    endtask

    task automatic random_march(input int n);
        int count, k;
        count = 0;
        while (count < n) begin
            case ($urandom_range(0, 9))
                0: begin
                    push_item(func_t'($urandom_range(0, 1)), $urandom_range(0, 511));
                    count++;
                end
                1: begin
                    // advances on whatever ray is left, often none
                    k = $urandom_range(1, 6);
                    repeat (k) push_item(FUNC_ADVANCE, $urandom_range(0, 511));
                    count += k;
                end
                default: begin
                    k = $urandom_range(1, 48);
                    push_ray($urandom_range(0, 511), k);
                    count += k + 1;
                end
            endcase
        end
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (item_queue.size() != 0 || s_tvalid || pixel_queue.size() != 0);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: advance with no ray, axis rays, restart mid-ray
        push_item(FUNC_ADVANCE, 0);
        push_ray(0, 3);
        push_ray(511, 2);
        push_ray(128, 1);
        push_ray(384, 1);
        drain();

        // saturation at the top of the position range, zero radius on the path
        setup(2047, 0, 2047, 0, 0, 2047, 2047);
        push_ray(0, 2);
        push_ray(64, 1);
        drain();

        // off screen and inside the circle on the same pixel
        setup(0, 50, 0, 50, 5, 100, 100);
        push_ray(256, 1);
        drain();

        // largest circle around the source
        setup(1024, 1024, 1024, 1024, 1023, 2047, 2047);
        push_ray(320, 2);
        drain();

        idle_on = 1'b1;
        random_setup(1'b0);
        random_march(260);
        drain();

        // long receiver stall with a fast sender fills the output buffer
        idle_on = 1'b0;
        random_setup(1'b0);
        random_march(260);
        stall_ticket++;
        drain();

        idle_on = 1'b1;
        random_setup(1'b0);
        random_march(260);
        drain();

        random_setup(1'b1);
        random_march(130);
        drain();
        random_march(130);
        drain();

        random_setup(1'b0);
        random_march(260);
        drain();

        random_setup(1'b1);
        random_march(260);
        drain();

        if (bad_words == 0 && pixel_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
